FILE: design/tclsr_pkg.sv
// ---------------------------------------------------------------------------
// tclsr_pkg
// Shared constants, types and helpers for the text command LED status
// responder.
// ---------------------------------------------------------------------------
package tclsr_pkg;

	localparam int LINE_MAX_DEF = 32;

	localparam int DT_W = 10;
	localparam logic [DT_W-1:0] DEBOUNCE_RST = 10'd50;
	localparam logic [DT_W-1:0] TICK_SAT     = 10'd1023;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam int HEAD_LEN = 7;

	localparam int IDX_W = 6;
	localparam logic [IDX_W-1:0] IDX_LAST = 6'd32;

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic       status;
		logic [3:0] leds;
		logic [1:0] btns;
	} tx_job_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic logic [7:0] bit_char(input logic b);
		return {7'b0011000, b};
	endfunction

	// Character idx of "S:L1:x,L2:x,L3:x,L4:x,B1:x,B2:x" CR LF
	function automatic logic [7:0] status_char(input logic [IDX_W-1:0] idx,
		input logic [3:0] leds, input logic [1:0] btns);
		logic [7:0] ch;
		case (idx)
			6'd0:  ch = "S";
			6'd1:  ch = ":";
			6'd2:  ch = "L";
			6'd3:  ch = "1";
			6'd4:  ch = ":";
			6'd5:  ch = bit_char(leds[0]);
			6'd6:  ch = ",";
			6'd7:  ch = "L";
			6'd8:  ch = "2";
			6'd9:  ch = ":";
			6'd10: ch = bit_char(leds[1]);
			6'd11: ch = ",";
			6'd12: ch = "L";
			6'd13: ch = "3";
			6'd14: ch = ":";
			6'd15: ch = bit_char(leds[2]);
			6'd16: ch = ",";
			6'd17: ch = "L";
			6'd18: ch = "4";
			6'd19: ch = ":";
			6'd20: ch = bit_char(leds[3]);
			6'd21: ch = ",";
			6'd22: ch = "B";
			6'd23: ch = "1";
			6'd24: ch = ":";
			6'd25: ch = bit_char(btns[0]);
			6'd26: ch = ",";
			6'd27: ch = "B";
			6'd28: ch = "2";
			6'd29: ch = ":";
			6'd30: ch = bit_char(btns[1]);
			6'd31: ch = CH_CR;
			6'd32: ch = CH_LF;
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

endpackage

FILE: design/tclsr_line.sv
// ---------------------------------------------------------------------------
// tclsr_line
// Line assembler and command decoder. Tracks the trimmed line as it arrives
// (head characters, trimmed length) so that LF decodes combinationally.
// ---------------------------------------------------------------------------
module tclsr_line #(
	parameter int LINE_MAX = tclsr_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	output logic       answer,
	output logic [3:0] leds_d
);

	localparam int LW = $clog2(LINE_MAX + 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(LINE_MAX);
	localparam logic [LW-1:0] HEAD_END = LW'(tclsr_pkg::HEAD_LEN);

	logic [LW-1:0] len_q;
	logic          long_q;
	logic [LW-1:0] rel_q;
	logic [LW-1:0] nlen_q;
	logic [3:0]    leds_q;
	logic [7:0]    head_q [tclsr_pkg::HEAD_LEN];

	logic          is_lf, is_cr, blank, room, keep;
	logic [LW-1:0] rel_inc;
	logic          prefix, status_word, digit_ok, led_on, led_cmd;
	logic [1:0]    digit;

	always_comb begin
		is_lf   = (rx_byte == tclsr_pkg::CH_LF);
		is_cr   = (rx_byte == tclsr_pkg::CH_CR);
		blank   = tclsr_pkg::is_blank(rx_byte);
		room    = (len_q != LEN_FULL);
		// leading blanks are dropped: count only once the line has started
		keep    = room && ((rel_q != '0) || !blank);
		rel_inc = rel_q + LW'(1);

		prefix = (nlen_q >= LW'(3)) && (head_q[0] == "L") && (head_q[1] == "E")
			&& (head_q[2] == "D");
		status_word = (nlen_q == LW'(6)) && (head_q[0] == "S") && (head_q[1] == "T")
			&& (head_q[2] == "A") && (head_q[3] == "T") && (head_q[4] == "U")
			&& (head_q[5] == "S");
		digit_ok = (head_q[3] >= "1") && (head_q[3] <= "4");
		digit    = head_q[3][1:0] - 2'd1;
		led_on   = (nlen_q == LW'(7)) && (head_q[5] == "O") && (head_q[6] == "N");
		led_cmd  = prefix && (nlen_q >= LW'(7)) && digit_ok;

		answer = fire && is_lf && !long_q && (prefix || status_word);
		leds_d = leds_q;
		if (fire && is_lf && !long_q && led_cmd) begin
			leds_d[digit] = led_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			long_q <= 1'b0;
			rel_q  <= '0;
			nlen_q <= '0;
			leds_q <= '0;
		end else if (fire) begin
			leds_q <= leds_d;
			if (is_lf) begin
				len_q  <= '0;
				long_q <= 1'b0;
				rel_q  <= '0;
				nlen_q <= '0;
			end else if (!is_cr) begin
				if (room) begin
					len_q <= len_q + LW'(1);
				end else begin
					long_q <= 1'b1;
				end
				if (keep) begin
					rel_q <= rel_inc;
					if (!blank) begin
						nlen_q <= rel_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !is_lf && !is_cr && keep && (rel_q < HEAD_END)) begin
			head_q[rel_q[2:0]] <= rx_byte;
		end
	end

endmodule

FILE: design/tclsr_debounce.sv
// ---------------------------------------------------------------------------
// tclsr_debounce
// Two-button debouncer counting stable millisecond ticks per button.
// ---------------------------------------------------------------------------
module tclsr_debounce (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [1:0]                  pins,
	input  logic [tclsr_pkg::DT_W-1:0]  debounce_ticks,
	output logic [1:0]                  btns_d
);

	logic [tclsr_pkg::DT_W-1:0] cnt_q [2];
	logic [tclsr_pkg::DT_W-1:0] cnt_n [2];
	logic [1:0]                 prev_q;
	logic [1:0]                 deb_q;
	logic [1:0]                 reading;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			reading[i] = ~pins[i];
			if (reading[i] != prev_q[i]) begin
				cnt_n[i] = '0;
			end else if (cnt_q[i] != tclsr_pkg::TICK_SAT) begin
				cnt_n[i] = cnt_q[i] + tclsr_pkg::DT_W'(1);
			end else begin
				cnt_n[i] = cnt_q[i];
			end
			btns_d[i] = (fire && (cnt_n[i] > debounce_ticks)) ? reading[i] : deb_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0] <= '0;
			cnt_q[1] <= '0;
			prev_q   <= '0;
			deb_q    <= '0;
		end else if (fire) begin
			cnt_q[0] <= cnt_n[0];
			cnt_q[1] <= cnt_n[1];
			prev_q   <= reading;
			deb_q    <= btns_d;
		end
	end

endmodule

FILE: design/tclsr_tx.sv
// ---------------------------------------------------------------------------
// tclsr_tx
// Result register and status line sequencer: holds one result, or steps
// through the 33 characters of a status answer.
// ---------------------------------------------------------------------------
module tclsr_tx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tclsr_pkg::tx_job_t   job,
	output logic                 free,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 tx_valid,
	output logic [7:0]           tx_byte,
	output logic                 last,
	output logic [3:0]           led_levels,
	output logic [1:0]           buttons_pressed
);

	logic                        busy_q;
	logic                        status_q;
	logic [tclsr_pkg::IDX_W-1:0] idx_q;
	logic [3:0]                  leds_q;
	logic [1:0]                  btns_q;

	assign out_valid       = busy_q;
	assign tx_valid        = status_q;
	assign tx_byte         = status_q ? tclsr_pkg::status_char(idx_q, leds_q, btns_q) : 8'd0;
	assign last            = !status_q || (idx_q == tclsr_pkg::IDX_LAST);
	assign led_levels      = leds_q;
	assign buttons_pressed = btns_q;
	assign free            = !busy_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			status_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			busy_q   <= 1'b1;
			status_q <= job.status;
			idx_q    <= '0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + tclsr_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			leds_q <= job.leds;
			btns_q <= job.btns;
		end
	end

endmodule

FILE: design/text_command_led_status_responder.sv
// Flow: an accepted item is registered in the input register, then loaded
// into the output register once that register is free.
// Throughput: one item per cycle while results are taken; a status answer
// occupies the output register for 33 results, so input stalls once the
// input register is full. Reset: LEDs off, buttons released, line empty,
// debounce threshold 50; no clearing pass.
// ---------------------------------------------------------------------------
// text_command_led_status_responder
// Text command responder: builds lines from received bytes, sets LEDs and
// answers with a status line; debounces two buttons on millisecond ticks.
// ---------------------------------------------------------------------------
module text_command_led_status_responder #(
	parameter int LINE_MAX = tclsr_pkg::LINE_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tclsr_pkg::DT_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic [7:0]                  rx_byte,
	input  logic [1:0]                  button_pins,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        tx_valid,
	output logic [7:0]                  tx_byte,
	output logic                        last,
	output logic [3:0]                  led_levels,
	output logic [1:0]                  buttons_pressed
);

	logic [tclsr_pkg::DT_W-1:0] dt_q;
	logic                       valid_s1;
	logic                       mode_s1;
	logic [7:0]                 byte_s1;
	logic [1:0]                 pins_s1;

	logic               tx_free, fire_s1, byte_fire, tick_fire, answer;
	logic [3:0]         leds_d;
	logic [1:0]         btns_d;
	tclsr_pkg::tx_job_t job;

	assign in_ready  = !valid_s1 || tx_free;
	assign fire_s1   = valid_s1 && tx_free;
	assign byte_fire = fire_s1 && (mode_s1 == tclsr_pkg::MODE_BYTE);
	assign tick_fire = fire_s1 && (mode_s1 == tclsr_pkg::MODE_TICK);

	always_comb begin
		job.status = answer;
		job.leds   = leds_d;
		job.btns   = btns_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= tclsr_pkg::DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			dt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
			pins_s1 <= button_pins;
		end
	end

	tclsr_line #(
		.LINE_MAX(LINE_MAX)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (byte_fire),
		.rx_byte (byte_s1),
		.answer  (answer),
		.leds_d  (leds_d)
	);

	tclsr_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (tick_fire),
		.pins           (pins_s1),
		.debounce_ticks (dt_q),
		.btns_d         (btns_d)
	);

	tclsr_tx u_tx (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (fire_s1),
		.job             (job),
		.free            (tx_free),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.last            (last),
		.led_levels      (led_levels),
		.buttons_pressed (buttons_pressed)
	);

	// hold a waiting item in the input register until the output side frees
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !tx_free |=> valid_s1)
		else $error("input register lost a waiting item");

	// a status burst runs on until its final LF
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && !last && out_ready |=> out_valid && tx_valid)
		else $error("status burst ended early");

	// input stalls while a burst is mid-way and the input register is full
	a_burst_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && !last && valid_s1 |-> !in_ready)
		else $error("item accepted over a running burst");

	// no item is dropped: a held result that is not taken stays pending unchanged
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last))
		else $error("pending result changed");

endmodule

FILE: sim/led_status_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_status_checker
// Watches both channels and the threshold write port of the responder. It
// keeps its own copy of the line buffer, LED states and button debouncers,
// works out the results of every accepted item and compares each accepted
// result with the oldest one still due.
// ---------------------------------------------------------------------------
module led_status_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [tclsr_pkg::DT_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        mode,
	input  logic [7:0]                  rx_byte,
	input  logic [1:0]                  button_pins,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        tx_valid,
	input  logic [7:0]                  tx_byte,
	input  logic                        last,
	input  logic [3:0]                  led_levels,
	input  logic [1:0]                  buttons_pressed,
	output int                          error_count,
	output int                          outstanding
);
	import tclsr_pkg::*;

	localparam int LINE_LEN = LINE_MAX_DEF;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic [3:0] leds;
		logic [1:0] btns;
	} reply_t;

	reply_t           replies_due[$];
	reply_t           want;
	int               errors = 0;

	logic [DT_W-1:0]  threshold;
	logic [3:0]       led_state;
	logic [7:0]       line_text [LINE_LEN];
	int               line_len;
	logic             overflow;
	logic [DT_W-1:0]  hold_ticks [2];
	logic [1:0]       last_read;
	logic [1:0]       held_press;

	function automatic logic is_gap(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

	// Trim and interpret the finished line; true when a status line is due.
	function automatic logic close_line();
		int         first;
		int         stop;
		int         n;
		logic       led_head;
		logic [1:0] lamp_idx;
		string      word;
		word = "STATUS";
		first = 0;
		stop = line_len;
		while (first < stop && is_gap(line_text[first]))
			first++;
		while (stop > first && is_gap(line_text[stop - 1]))
			stop--;
		n = stop - first;
		led_head = n >= 3 && line_text[first] == "L" && line_text[first + 1] == "E"
			&& line_text[first + 2] == "D";
		if (led_head && n >= HEAD_LEN) begin
			if (line_text[first + 3] >= "1" && line_text[first + 3] <= "4") begin
				lamp_idx = line_text[first + 3][1:0] - 2'd1;
				led_state[lamp_idx] = n == HEAD_LEN && line_text[first + 5] == "O"
					&& line_text[first + 6] == "N";
			end
		end
		if (led_head)
			return 1'b1;
		if (n != word.len())
			return 1'b0;
		for (int k = 0; k < n; k++) begin
			if (line_text[first + k] != word[k])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] reply_char(input int k);
		string frame;
		int    slot;
		logic  flag;
		frame = "S:L1:x,L2:x,L3:x,L4:x,B1:x,B2:x";
		if (k == int'(IDX_LAST) - 1)
			return CH_CR;
		if (k == int'(IDX_LAST))
			return CH_LF;
		if (k >= 5 && k % 5 == 0) begin
			slot = k / 5 - 1;
			flag = (slot < 4) ? led_state[slot] : held_press[slot - 4];
			return flag ? "1" : "0";
		end
		return frame[k];
	endfunction

	task automatic take_item(input logic m, input logic [7:0] ch, input logic [1:0] pins);
		logic answer;
		logic reading;
		answer = 1'b0;
		if (m == MODE_BYTE) begin
			if (ch == CH_LF) begin
				if (!overflow)
					answer = close_line();
				line_len = 0;
				overflow = 1'b0;
			end else if (ch != CH_CR) begin
				if (line_len < LINE_LEN) begin
					line_text[line_len] = ch;
					line_len++;
				end else begin
					overflow = 1'b1;
				end
			end
		end else begin
			for (int btn = 0; btn < 2; btn++) begin
				reading = !pins[btn];
				if (reading != last_read[btn])
					hold_ticks[btn] = '0;
				else if (hold_ticks[btn] < TICK_SAT)
					hold_ticks[btn] = hold_ticks[btn] + 1'b1;
				if (hold_ticks[btn] > threshold)
					held_press[btn] = reading;
				last_read[btn] = reading;
			end
		end
		if (answer) begin
			for (int k = 0; k <= int'(IDX_LAST); k++)
				replies_due.push_back('{1'b1, reply_char(k), k == int'(IDX_LAST),
					led_state, held_press});
		end else begin
			replies_due.push_back('{1'b0, 8'd0, 1'b1, led_state, held_press});
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_val,
		input logic [7:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = DEBOUNCE_RST;
			led_state = '0;
			line_len = 0;
			overflow = 1'b0;
			hold_ticks[0] = '0;
			hold_ticks[1] = '0;
			last_read = '0;
			held_press = '0;
			replies_due.delete();
			outstanding <= 0;
			error_count <= errors;
		end else begin
			if (cfg_wr_en)
				threshold = cfg_wr_data;
			if (in_valid && in_ready)
				take_item(mode, rx_byte, button_pins);
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result with none due: tx_byte %0h last %0b", tx_byte, last);
					errors++;
				end else begin
					want = replies_due.pop_front();
					check_field("tx_valid", want.tx_valid, tx_valid);
					check_field("tx_byte", want.tx_byte, tx_byte);
					check_field("last", want.last, last);
					check_field("led_levels", want.leds, led_levels);
					check_field("buttons_pressed", want.btns, buttons_pressed);
				end
			end
			// publish after the edge so the stimulus side reads settled counts
			outstanding <= replies_due.size();
			error_count <= errors;
		end
	end

endmodule

FILE: sim/tb_text_command_led_status_responder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_command_led_status_responder
// Feeds command lines, button ticks and stray bytes to the responder under
// several debounce thresholds and idle profiles; the checker beside the block
// predicts every result and counts mismatches for the final verdict.
// ---------------------------------------------------------------------------
module tb_text_command_led_status_responder;
	import tclsr_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [DT_W-1:0]     cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                mode = MODE_BYTE;
	logic [7:0]          rx_byte = '0;
	logic [1:0]          button_pins = 2'b11;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                tx_valid;
	logic [7:0]          tx_byte;
	logic                last;
	logic [3:0]          led_levels;
	logic [1:0]          buttons_pressed;

	int                  error_count;
	int                  outstanding;
	int                  send_idle_pct = 21;
	int                  recv_idle_pct = 82;
	int                  items_sent = 0;

	text_command_led_status_responder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.rx_byte         (rx_byte),
		.button_pins     (button_pins),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.last            (last),
		.led_levels      (led_levels),
		.buttons_pressed (buttons_pressed)
	);

	led_status_checker reply_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.rx_byte         (rx_byte),
		.button_pins     (button_pins),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.last            (last),
		.led_levels      (led_levels),
		.buttons_pressed (buttons_pressed),
		.error_count     (error_count),
		.outstanding     (outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic push_item(input logic m, input logic [7:0] b, input logic [1:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		rx_byte     <= b;
		button_pins <= p;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(MODE_BYTE, b, 2'($urandom_range(3)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	task automatic send_blanks();
		repeat ($urandom_range(2))
			push_byte(pick_blank());
	endtask

	task automatic end_line();
		if ($urandom_range(1))
			push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic led_command();
		logic [7:0] digit;
		logic [7:0] gap;
		send_blanks();
		send_text("LED");
		digit = ($urandom_range(4) != 0) ? 8'("1" + $urandom_range(3)) : 8'($urandom_range(255));
		if (digit == CH_LF)
			digit = "0";
		push_byte(digit);
		gap = ($urandom_range(3) != 0) ? CH_SPACE : 8'($urandom_range(255));
		if (gap == CH_LF)
			gap = "x";
		push_byte(gap);
		case ($urandom_range(5))
			0, 1, 2: send_text("ON");
			3: send_text("OFF");
			4: send_text("ONX");
			default: send_text("O");
		endcase
		send_blanks();
		end_line();
	endtask

	task automatic status_request();
		send_blanks();
		if ($urandom_range(9) == 0)
			send_text("STATUX");
		else
			send_text("STATUS");
		send_blanks();
		end_line();
	endtask

	task automatic short_led_line();
		send_text("LED");
		repeat ($urandom_range(3))
			push_byte(8'($urandom_range(32, 126)));
		end_line();
	endtask

	// Exactly full buffer is still interpreted; anything longer is dropped.
	task automatic long_line();
		int span;
		span = $urandom_range(1) ? LINE_MAX_DEF : LINE_MAX_DEF + $urandom_range(1, 8);
		send_text("LED");
		push_byte(8'("1" + $urandom_range(3)));
		repeat (span - 4)
			push_byte(8'($urandom_range(33, 126)));
		push_byte(CH_LF);
	endtask

	task automatic noise_bytes();
		repeat ($urandom_range(1, 4))
			push_byte(8'($urandom_range(255)));
	endtask

	task automatic tick_run(input logic [1:0] pins, input int count, input int flip_pct);
		logic [1:0] level;
		level = pins;
		repeat (count) begin
			if ($urandom_range(99) < flip_pct)
				level[$urandom_range(1)] = ~level[$urandom_range(1)];
			push_item(MODE_TICK, 8'($urandom_range(255)), level);
		end
	endtask

	task automatic random_sequence();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			led_command();
		else if (pick < 47)
			status_request();
		else if (pick < 54)
			short_led_line();
		else if (pick < 60)
			long_line();
		else if (pick < 82)
			tick_run(2'($urandom_range(3)), $urandom_range(1, 8), 10);
		else
			noise_bytes();
	endtask

	task automatic run_random(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count)
			random_sequence();
	endtask

	// Drain, let the pipeline settle, then write the threshold.
	task automatic set_threshold(input logic [DT_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		#4_000_000;
		$display("tb_text_command_led_status_responder failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// position 4 unchecked, highest LED number
		send_text("LED4xON");
		push_byte(CH_LF);
		// blanks trimmed on both sides, CR dropped
		push_byte(CH_SPACE);
		send_text("STATUS");
		push_byte(CH_TAB);
		push_byte(CH_CR);
		push_byte(CH_LF);
		// short LED line with extreme byte values
		send_text("LED");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(CH_LF);
		push_item(MODE_TICK, 8'hFF, 2'b00);
		push_item(MODE_TICK, 8'h00, 2'b11);
		// hold button 1 past the reset threshold
		tick_run(2'b10, 55, 0);
		run_random(60);

		set_threshold('0);
		run_random(60);
		tick_run(2'b11, 3, 0);

		send_idle_pct = 82;
		recv_idle_pct = 21;
		set_threshold(TICK_SAT);
		run_random(50);
		// hold both pressed; the top threshold never adopts a reading
		tick_run(2'b00, 40, 0);
		set_threshold(10'd1000);
		push_item(MODE_TICK, 8'h5A, 2'b00);
		run_random(40);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_threshold(DT_W'($urandom_range(1, 6)));
		run_random(60);

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb_text_command_led_status_responder passed");
		else
			$display("tb_text_command_led_status_responder failed");
		$finish;
	end

endmodule
